// ===== rtl/rbwd_pkg.sv =====
package rbwd_pkg;

    localparam logic signed [31:0] Q30_ONE   = 32'sh4000_0000;
    localparam logic        [30:0] CFG_RESET = 31'd65536;

    localparam logic [2:0] CFG_MAX_TORQUE    = 3'd0;
    localparam logic [2:0] CFG_WHEEL_INERTIA = 3'd1;
    localparam logic [2:0] CFG_MAX_SPEED     = 3'd2;
    localparam logic [2:0] CFG_INERTIA_X     = 3'd3;
    localparam logic [2:0] CFG_INERTIA_Y     = 3'd4;
    localparam logic [2:0] CFG_INERTIA_Z     = 3'd5;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LD,
        OP_MUL_L,
        OP_L_SET,
        OP_MUL_GA,
        OP_MUL_GB,
        OP_G_SET,
        OP_T_CLAMP,
        OP_MUL_TDT,
        OP_DIV_WH,
        OP_NW_SET,
        OP_MUL_DW,
        OP_DIV_R,
        OP_NET_SET,
        OP_DIV_D,
        OP_D_SET,
        OP_MUL_DDT,
        OP_RATE_SET,
        OP_MUL_H,
        OP_H_SET,
        OP_QN_INIT,
        OP_MUL_Q,
        OP_ACC_Q,
        OP_V_SET,
        OP_NRM_SHIFT,
        OP_SUM_CLR,
        OP_SQ,
        OP_SUM_LAST,
        OP_SQRT,
        OP_DIV_N,
        OP_ATT_SET
    } op_t;

    typedef struct packed {
        logic       valid;
        op_t        op;
        logic [1:0] ax;
        logic [1:0] bx;
        logic       neg;
    } cmd_t;

    typedef struct packed {
        logic req;
        logic dt_pos;
        logic div_busy;
        logic sqrt_busy;
        logic norm_ok;
    } stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fff_ffff;
        end
        else if (v < -66'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_abs(input logic signed [65:0] v,
                                                     input logic [30:0] m);
        logic signed [65:0] mm;
        logic signed [65:0] nm;
        mm = $signed({35'd0, m});
        nm = -mm;
        if (v > mm) begin
            return mm[31:0];
        end
        else if (v < nm) begin
            return nm[31:0];
        end
        return v[31:0];
    endfunction

    function automatic logic [1:0] axis_next1(input logic [1:0] a);
        return (a == 2'd2) ? 2'd0 : 2'(a + 2'd1);
    endfunction

    function automatic logic [1:0] axis_next2(input logic [1:0] a);
        return (a == 2'd0) ? 2'd2 : 2'(a - 2'd1);
    endfunction

endpackage

// ===== rtl/rbwd_div.sv =====
module rbwd_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic        [30:0] den,
    output logic               busy,
    output logic signed [63:0] quot
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] bits_reg;
    logic [30:0] rem_reg;
    logic [30:0] den_reg;
    logic        neg_reg;
    logic [31:0] shifted;
    logic        fits;
    logic [63:0] num_mag;

    assign shifted = {rem_reg, bits_reg[63]};
    assign fits    = shifted >= {1'b0, den_reg};
    assign num_mag = num[63] ? 64'(-num) : 64'(num);
    assign busy    = busy_reg;
    assign quot    = neg_reg ? -$signed(bits_reg) : $signed(bits_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= (den != '0);
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd63)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= 6'(cnt_reg + 6'd1);
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[63];
            den_reg <= den;
            rem_reg <= '0;
            if (den == '0)
            begin
                bits_reg <= (num == '0) ? 64'd0 : 64'h4000_0000_0000_0000;
            end
            else
            begin
                bits_reg <= num_mag;
            end
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? 31'(shifted - {1'b0, den_reg}) : shifted[30:0];
            bits_reg <= {bits_reg[62:0], fits};
        end
    end

endmodule

// ===== rtl/rbwd_sqrt.sv =====
module rbwd_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [61:0] x,
    output logic        busy,
    output logic [30:0] root
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [61:0] x_reg;
    logic [32:0] rem_reg;
    logic [30:0] root_reg;
    logic [34:0] rsh;
    logic [34:0] trial;
    logic        fits;

    assign rsh   = {rem_reg, x_reg[61:60]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign fits  = rsh >= trial;
    assign busy  = busy_reg;
    assign root  = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 5'd30)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= 5'(cnt_reg + 5'd1);
        end
    end

    // two radicand bits per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[59:0], 2'b00};
            rem_reg  <= fits ? 33'(rsh - trial) : rsh[32:0];
            root_reg <= {root_reg[29:0], fits};
        end
    end

endmodule

// ===== rtl/rbwd_datapath.sv =====
module rbwd_datapath import rbwd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_load,
    input  logic         in_req,
    input  logic [351:0] in_data,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_idx,
    input  logic [30:0]  cfg_val,
    input  cmd_t         cmd,
    output stat_t        stat,
    output logic [319:0] res_data,
    output logic         res_skipped
);

    logic signed [31:0] q_reg [4];
    logic signed [31:0] rate_reg [3];
    logic signed [31:0] wheel_reg [3];
    logic        [30:0] mwt_reg;
    logic        [30:0] jw_reg;
    logic        [30:0] mws_reg;
    logic        [30:0] inert_reg [3];
    logic               req_reg;
    logic               skipped_reg;

    logic signed [31:0] tq_reg [3];
    logic signed [31:0] dt_reg;
    logic signed [31:0] lq_reg [4];
    logic signed [31:0] lr_reg [3];
    logic signed [31:0] lmom_reg [3];
    logic signed [31:0] gyro_reg [3];
    logic signed [31:0] h_reg [3];
    logic signed [63:0] v_reg [4];
    logic signed [63:0] p_reg;
    logic signed [63:0] a_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] nw_reg;
    logic signed [31:0] net_reg;
    logic        [63:0] sum_reg;
    logic               zero_reg;

    logic        [1:0]  ri;
    logic        [1:0]  li;
    logic signed [31:0] rate_sel;
    logic signed [31:0] lmom_sel;
    logic signed [31:0] q_sel;
    logic signed [31:0] h_sel;
    logic signed [63:0] v_sel;
    logic signed [31:0] tq_sel;
    logic signed [31:0] wheel_sel;
    logic signed [31:0] gyro_sel;
    logic        [30:0] inert_sel;
    logic signed [32:0] ma;
    logic signed [31:0] mb;
    logic signed [64:0] prod;
    logic signed [32:0] diff_w;
    logic signed [31:0] react;

    logic               div_start;
    logic signed [63:0] div_num;
    logic        [30:0] div_den;
    logic               div_busy;
    logic signed [63:0] quot;
    logic               sqrt_start;
    logic               sqrt_busy;
    logic        [30:0] root;

    logic        [63:0] mag [4];
    logic        [63:0] mx;
    logic               vz;
    logic signed [31:0] dt_in;

    assign dt_in = in_data[127:96];

    always_comb
    begin
        ri = cmd.ax;
        li = cmd.ax;
        if (cmd.op == OP_MUL_GA)
        begin
            ri = axis_next1(cmd.ax);
            li = axis_next2(cmd.ax);
        end
        else if (cmd.op == OP_MUL_GB)
        begin
            ri = axis_next2(cmd.ax);
            li = axis_next1(cmd.ax);
        end
    end

    assign rate_sel  = rate_reg[ri];
    assign lmom_sel  = lmom_reg[li];
    assign q_sel     = q_reg[cmd.ax];
    assign h_sel     = h_reg[cmd.bx];
    assign v_sel     = v_reg[cmd.ax];
    assign tq_sel    = tq_reg[cmd.ax];
    assign wheel_sel = wheel_reg[cmd.ax];
    assign gyro_sel  = gyro_reg[cmd.ax];
    assign inert_sel = inert_reg[cmd.ax];
    assign diff_w    = {nw_reg[31], nw_reg} - {wheel_sel[31], wheel_sel};
    assign react     = sat32(-66'(quot));

    // single shared multiplier, result lands in p_reg
    always_comb
    begin
        ma = 33'(rate_sel);
        mb = dt_reg;
        unique case (cmd.op)
            OP_MUL_L:
            begin
                ma = $signed({2'b00, inert_sel});
                mb = rate_sel;
            end
            OP_MUL_GA, OP_MUL_GB:
            begin
                ma = 33'(rate_sel);
                mb = lmom_sel;
            end
            OP_MUL_TDT:
            begin
                ma = 33'(t_reg);
                mb = dt_reg;
            end
            OP_MUL_DW:
            begin
                ma = diff_w;
                mb = $signed({1'b0, jw_reg});
            end
            OP_MUL_DDT:
            begin
                ma = 33'(net_reg);
                mb = dt_reg;
            end
            OP_MUL_Q:
            begin
                ma = 33'(q_sel);
                mb = h_sel;
            end
            OP_SQ:
            begin
                ma = v_sel[32:0];
                mb = v_sel[31:0];
            end
            default:
            begin
                ma = 33'(rate_sel);
                mb = dt_reg;
            end
        endcase
    end

    assign prod = ma * mb;

    always_comb
    begin
        div_start = cmd.valid;
        div_num   = p_reg;
        div_den   = jw_reg;
        unique case (cmd.op)
            OP_DIV_WH:
            begin
                div_num = -p_reg;
                div_den = jw_reg;
            end
            OP_DIV_R:
            begin
                div_num = p_reg;
                div_den = dt_reg[30:0];
            end
            OP_DIV_D:
            begin
                div_num = 64'(net_reg) <<< 16;
                div_den = inert_sel;
            end
            OP_DIV_N:
            begin
                div_num = v_sel <<< 30;
                div_den = root;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign sqrt_start = cmd.valid && (cmd.op == OP_SQRT);

    rbwd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (quot)
    );

    rbwd_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .x     (sum_reg[61:0]),
        .busy  (sqrt_busy),
        .root  (root)
    );

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = v_reg[i][63] ? 64'(-v_reg[i]) : 64'(v_reg[i]);
        end
        mx = mag[0];
        for (int i = 1; i < 4; i++)
        begin
            if (mag[i] > mx)
            begin
                mx = mag[i];
            end
        end
        vz = (mx == '0);
    end

    assign stat.req       = req_reg;
    assign stat.dt_pos    = !dt_reg[31] && (dt_reg != '0);
    assign stat.div_busy  = div_busy;
    assign stat.sqrt_busy = sqrt_busy;
    assign stat.norm_ok   = vz || ((mx[63:30] == '0) && mx[29]);

    assign res_data = {wheel_reg[2], wheel_reg[1], wheel_reg[0],
                       rate_reg[2], rate_reg[1], rate_reg[0],
                       q_reg[3], q_reg[2], q_reg[1], q_reg[0]};
    assign res_skipped = skipped_reg;

    // architectural state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg[0] <= Q30_ONE;
            q_reg[1] <= '0;
            q_reg[2] <= '0;
            q_reg[3] <= '0;
            for (int i = 0; i < 3; i++)
            begin
                rate_reg[i]  <= '0;
                wheel_reg[i] <= '0;
                inert_reg[i] <= CFG_RESET;
            end
            mwt_reg     <= CFG_RESET;
            jw_reg      <= CFG_RESET;
            mws_reg     <= CFG_RESET;
            req_reg     <= 1'b0;
            skipped_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_MAX_TORQUE:    mwt_reg      <= cfg_val;
                    CFG_WHEEL_INERTIA: jw_reg       <= cfg_val;
                    CFG_MAX_SPEED:     mws_reg      <= cfg_val;
                    CFG_INERTIA_X:     inert_reg[0] <= cfg_val;
                    CFG_INERTIA_Y:     inert_reg[1] <= cfg_val;
                    CFG_INERTIA_Z:     inert_reg[2] <= cfg_val;
                    default:
                    begin
                    end
                endcase
            end
            if (in_load)
            begin
                req_reg     <= in_req;
                skipped_reg <= !in_req && (dt_in <= 32'sd0);
            end
            if (cmd.valid)
            begin
                case (cmd.op)
                    OP_LD:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            rate_reg[i]  <= lr_reg[i];
                            wheel_reg[i] <= '0;
                        end
                    end
                    OP_NET_SET:
                    begin
                        wheel_reg[cmd.ax] <= nw_reg;
                    end
                    OP_RATE_SET:
                    begin
                        rate_reg[cmd.ax] <= sat32(66'(rate_sel) + 66'(p_reg >>> 16));
                    end
                    OP_ATT_SET:
                    begin
                        if (zero_reg)
                        begin
                            q_reg[cmd.ax] <= (cmd.ax == 2'd0) ? Q30_ONE : 32'sd0;
                        end
                        else
                        begin
                            q_reg[cmd.ax] <= sat32(66'(quot));
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tq_reg[i] <= in_data[32*i +: 32];
                lr_reg[i] <= in_data[32*(i+8) +: 32];
            end
            dt_reg <= dt_in;
            for (int i = 0; i < 4; i++)
            begin
                lq_reg[i] <= in_data[32*(i+4) +: 32];
            end
        end
        if (cmd.valid)
        begin
            case (cmd.op)
                OP_LD:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        v_reg[i] <= 64'(lq_reg[i]);
                    end
                end
                OP_MUL_L, OP_MUL_GA, OP_MUL_TDT, OP_MUL_DW, OP_MUL_DDT,
                OP_MUL_H, OP_MUL_Q:
                begin
                    p_reg <= prod[63:0];
                end
                OP_MUL_GB:
                begin
                    a_reg <= p_reg;
                    p_reg <= prod[63:0];
                end
                OP_L_SET:
                begin
                    lmom_reg[cmd.ax] <= sat32(66'(p_reg >>> 16));
                end
                OP_G_SET:
                begin
                    gyro_reg[cmd.ax] <= sat32((66'(a_reg) - 66'(p_reg)) >>> 16);
                end
                OP_T_CLAMP:
                begin
                    t_reg <= clamp_abs(66'(tq_sel), mwt_reg);
                end
                OP_NW_SET:
                begin
                    nw_reg <= clamp_abs(66'(wheel_sel) + 66'(quot), mws_reg);
                end
                OP_NET_SET:
                begin
                    net_reg <= sat32(66'(react) - 66'(gyro_sel));
                end
                OP_D_SET:
                begin
                    net_reg <= sat32(66'(quot));
                end
                OP_H_SET:
                begin
                    h_reg[cmd.ax] <= sat32(66'(p_reg >>> 17));
                end
                OP_QN_INIT:
                begin
                    a_reg <= 64'(q_sel);
                end
                OP_ACC_Q:
                begin
                    a_reg <= cmd.neg ? a_reg - (p_reg >>> 16) : a_reg + (p_reg >>> 16);
                end
                OP_V_SET:
                begin
                    v_reg[cmd.ax] <= a_reg;
                end
                OP_NRM_SHIFT:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        v_reg[i] <= (mx[63:30] != '0) ? (v_reg[i] >>> 1) : (v_reg[i] <<< 1);
                    end
                end
                OP_SUM_CLR:
                begin
                    sum_reg  <= '0;
                    p_reg    <= '0;
                    zero_reg <= vz;
                end
                OP_SQ:
                begin
                    sum_reg <= sum_reg + p_reg;
                    p_reg   <= prod[63:0];
                end
                OP_SUM_LAST:
                begin
                    sum_reg <= sum_reg + p_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/rbwd_ctrl.sv =====
module rbwd_ctrl import rbwd_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_accept,
    input  logic  out_free,
    input  stat_t stat,
    output logic  in_ready,
    output logic  out_load,
    output cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOAD,
        S_LMOM,
        S_GYRO,
        S_AXIS,
        S_HALF,
        S_QUAT,
        S_NORM,
        S_NDIV,
        S_DONE
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    state_t     follow;
    logic [3:0] stp_reg;
    logic [3:0] stp_next;
    logic [1:0] ax_reg;
    logic [1:0] ax_next;
    logic       wait_reg;
    logic       wait_next;
    logic [3:0] last_stp;
    logic [1:0] last_ax;
    logic [1:0] tm;
    logic [4:0] term;
    logic       busy_op;
    logic       advance;

    // per term: q index, h index, subtract
    function automatic logic [4:0] quat_term(input logic [1:0] k, input logic [1:0] t);
        logic [4:0] r;
        unique case ({k, t})
            4'b00_00: r = {2'd1, 2'd0, 1'b1};
            4'b00_01: r = {2'd2, 2'd1, 1'b1};
            4'b00_10: r = {2'd3, 2'd2, 1'b1};
            4'b01_00: r = {2'd0, 2'd0, 1'b0};
            4'b01_01: r = {2'd2, 2'd2, 1'b0};
            4'b01_10: r = {2'd3, 2'd1, 1'b1};
            4'b10_00: r = {2'd0, 2'd1, 1'b0};
            4'b10_01: r = {2'd3, 2'd0, 1'b0};
            4'b10_10: r = {2'd1, 2'd2, 1'b1};
            4'b11_00: r = {2'd0, 2'd2, 1'b0};
            4'b11_01: r = {2'd1, 2'd1, 1'b0};
            4'b11_10: r = {2'd2, 2'd0, 1'b1};
            default:  r = '0;
        endcase
        return r;
    endfunction

    assign tm   = 2'((stp_reg - 4'd1) >> 1);
    assign term = quat_term(ax_reg, tm);

    always_comb
    begin
        cmd.valid = 1'b0;
        cmd.op    = OP_NOP;
        cmd.ax    = ax_reg;
        cmd.bx    = 2'd0;
        cmd.neg   = 1'b0;
        last_stp  = 4'd0;
        last_ax   = 2'd0;
        follow    = S_DONE;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.op = OP_LD;
                follow = S_NORM;
            end
            S_LMOM:
            begin
                cmd.op   = (stp_reg == 4'd0) ? OP_MUL_L : OP_L_SET;
                last_stp = 4'd1;
                last_ax  = 2'd2;
                follow   = S_GYRO;
            end
            S_GYRO:
            begin
                unique case (stp_reg)
                    4'd0:    cmd.op = OP_MUL_GA;
                    4'd1:    cmd.op = OP_MUL_GB;
                    default: cmd.op = OP_G_SET;
                endcase
                last_stp = 4'd2;
                last_ax  = 2'd2;
                follow   = S_AXIS;
            end
            S_AXIS:
            begin
                unique case (stp_reg)
                    4'd0:    cmd.op = OP_T_CLAMP;
                    4'd1:    cmd.op = OP_MUL_TDT;
                    4'd2:    cmd.op = OP_DIV_WH;
                    4'd3:    cmd.op = OP_NW_SET;
                    4'd4:    cmd.op = OP_MUL_DW;
                    4'd5:    cmd.op = OP_DIV_R;
                    4'd6:    cmd.op = OP_NET_SET;
                    4'd7:    cmd.op = OP_DIV_D;
                    4'd8:    cmd.op = OP_D_SET;
                    4'd9:    cmd.op = OP_MUL_DDT;
                    default: cmd.op = OP_RATE_SET;
                endcase
                last_stp = 4'd10;
                last_ax  = 2'd2;
                follow   = S_HALF;
            end
            S_HALF:
            begin
                cmd.op   = (stp_reg == 4'd0) ? OP_MUL_H : OP_H_SET;
                last_stp = 4'd1;
                last_ax  = 2'd2;
                follow   = S_QUAT;
            end
            S_QUAT:
            begin
                if (stp_reg == 4'd0)
                begin
                    cmd.op = OP_QN_INIT;
                end
                else if (stp_reg == 4'd7)
                begin
                    cmd.op = OP_V_SET;
                end
                else if (stp_reg[0])
                begin
                    cmd.op = OP_MUL_Q;
                    cmd.ax = term[4:3];
                    cmd.bx = term[2:1];
                end
                else
                begin
                    cmd.op  = OP_ACC_Q;
                    cmd.neg = term[0];
                end
                last_stp = 4'd7;
                last_ax  = 2'd3;
                follow   = S_NORM;
            end
            S_NORM:
            begin
                unique case (stp_reg)
                    4'd0:    cmd.op = OP_NRM_SHIFT;
                    4'd1:    cmd.op = OP_SUM_CLR;
                    4'd2, 4'd3, 4'd4, 4'd5:
                    begin
                        cmd.op = OP_SQ;
                        cmd.ax = 2'(stp_reg - 4'd2);
                    end
                    4'd6:    cmd.op = OP_SUM_LAST;
                    default: cmd.op = OP_SQRT;
                endcase
                last_stp = 4'd7;
                follow   = S_NDIV;
            end
            S_NDIV:
            begin
                cmd.op   = (stp_reg == 4'd0) ? OP_DIV_N : OP_ATT_SET;
                last_stp = 4'd1;
                last_ax  = 2'd3;
                follow   = S_DONE;
            end
            default:
            begin
                cmd.op = OP_NOP;
            end
        endcase

        busy_op = (cmd.op == OP_DIV_WH) || (cmd.op == OP_DIV_R) || (cmd.op == OP_DIV_D)
               || (cmd.op == OP_DIV_N) || (cmd.op == OP_SQRT);
        advance   = 1'b0;
        wait_next = wait_reg;
        if (wait_reg)
        begin
            if (!stat.div_busy && !stat.sqrt_busy)
            begin
                advance   = 1'b1;
                wait_next = 1'b0;
            end
        end
        else if (cmd.op == OP_NRM_SHIFT)
        begin
            // shift until the largest part sits in [2^29, 2^30), or go on at once if all parts are zero
            if (stat.norm_ok)
            begin
                advance = 1'b1;
            end
            else
            begin
                cmd.valid = 1'b1;
            end
        end
        else if (cmd.op != OP_NOP)
        begin
            cmd.valid = 1'b1;
            if (busy_op)
            begin
                wait_next = 1'b1;
            end
            else
            begin
                advance = 1'b1;
            end
        end

        state_next = state_reg;
        stp_next   = stp_reg;
        ax_next    = ax_reg;
        if (advance)
        begin
            if (stp_reg < last_stp)
            begin
                stp_next = 4'(stp_reg + 4'd1);
            end
            else if (ax_reg < last_ax)
            begin
                stp_next = '0;
                ax_next  = 2'(ax_reg + 2'd1);
            end
            else
            begin
                stp_next   = '0;
                ax_next    = '0;
                state_next = follow;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (stat.req)
                begin
                    state_next = S_LOAD;
                end
                else if (stat.dt_pos)
                begin
                    state_next = S_LMOM;
                end
                else
                begin
                    state_next = S_DONE;
                end
                stp_next = '0;
                ax_next  = '0;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stp_reg   <= '0;
            ax_reg    <= '0;
            wait_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stp_reg   <= stp_next;
            ax_reg    <= ax_next;
            wait_reg  <= wait_next;
        end
    end

    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(stat.div_busy || stat.sqrt_busy))
        else $error("arithmetic unit busy while idle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result loaded into occupied output register");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && (cmd.op == OP_DIV_WH || cmd.op == OP_DIV_R || cmd.op == OP_DIV_D
                       || cmd.op == OP_DIV_N)) |-> !stat.div_busy)
        else $error("divider restarted while busy");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ready)
        else $error("second item taken before first finished");

endmodule

// ===== rtl/rigid_body_wheel_dynamics_step_core.sv =====
// time from accept to result valid depends mostly on the serial divider (9 divides per
// propagate and 4 in the normalization), the serial square root and the shift count
// one item is in work at a time; the next is taken once the result is in the output register
// reset: attitude (1,0,0,0), body rate and wheel speeds zero, all config registers 1.0
module rigid_body_wheel_dynamics_step_core import rbwd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // torque_x, torque_y, torque_z, time_step, load_qw, load_qx, load_qy, load_qz,
    // load_rate_x, load_rate_y, load_rate_z
    input  logic [351:0] s_tdata,
    // req_type
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // att_w, att_x, att_y, att_z, rate_x, rate_y, rate_z, wheel_x, wheel_y, wheel_z
    output logic [319:0] m_tdata,
    // step_skipped
    output logic         m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    cmd_t         cmd;
    stat_t        stat;
    logic         in_accept;
    logic         in_ready;
    logic         out_load;
    logic         out_free;
    logic [319:0] res_data;
    logic         res_skipped;
    logic         m_valid_reg;
    logic [319:0] m_data_reg;
    logic         m_user_reg;

    assign s_tready  = in_ready;
    assign in_accept = s_tvalid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    rbwd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .out_free  (out_free),
        .stat      (stat),
        .in_ready  (in_ready),
        .out_load  (out_load),
        .cmd       (cmd)
    );

    rbwd_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_load     (in_accept),
        .in_req      (s_tuser),
        .in_data     (s_tdata),
        .cfg_we      (cfg_valid),
        .cfg_idx     (cfg_index),
        .cfg_val     (cfg_data[30:0]),
        .cmd         (cmd),
        .stat        (stat),
        .res_data    (res_data),
        .res_skipped (res_skipped)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= res_data;
            m_user_reg <= res_skipped;
        end
    end

endmodule

// ===== bench/tb_rigid_body_wheel_dynamics_step_core.sv =====
`timescale 1ns / 1ps

module tb_rigid_body_wheel_dynamics_step_core;
    import rbwd_pkg::*;

    typedef struct {
        logic               load;
        logic signed [31:0] tq [3];
        logic signed [31:0] dt;
        logic signed [31:0] lq [4];
        logic signed [31:0] lr [3];
    } step_req_t;

    typedef struct {
        logic [319:0] data;
        logic         skipped;
    } state_out_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [351:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [319:0] m_tdata;
    logic         m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    // handshake seen at the last rising edge, so the driver knows the item went
    logic         s_tready_q;

    rigid_body_wheel_dynamics_step_core dut (.*);

    // predictor state
    longint lim_torque, jw, lim_speed;
    longint inert [3];
    longint att [4];
    longint rate [3];
    longint wheel [3];

    step_req_t  pending_steps [$];
    state_out_t expected_states [$];
    int         errors;
    int         gap_left;
    int         stall_left;
    bit         feeding;

    function automatic longint sat32f(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint div_big(longint num, longint den);
        if (den == 0) return num > 0 ? 64'sh4000_0000_0000_0000 :
                             (num < 0 ? -64'sh4000_0000_0000_0000 : 0);
        return num / den;
    endfunction

    function automatic longint clampm(longint v, longint m);
        if (v > m) return m;
        if (v < -m) return -m;
        return v;
    endfunction

    function automatic longint maxmag(longint v [4]);
        longint m;
        m = 0;
        foreach (v[i]) if ((v[i] < 0 ? -v[i] : v[i]) > m) m = v[i] < 0 ? -v[i] : v[i];
        return m;
    endfunction

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    task automatic renormalize(input longint c [4]);
        longint v [4];
        longint unsigned sum;
        longint n;
        v = c;
        if (maxmag(v) == 0) begin
            att = '{64'sd1073741824, 0, 0, 0};
            return;
        end
        while (maxmag(v) >= 64'sd1073741824) foreach (v[i]) v[i] = v[i] >>> 1;
        while (maxmag(v) < 64'sd536870912) foreach (v[i]) v[i] = v[i] * 2;
        sum = 0;
        foreach (v[i]) sum += v[i] * v[i];
        n = int_sqrt(sum);
        foreach (v[i]) att[i] = sat32f(div_big(v[i] * 64'sd1073741824, n));
    endtask

    task automatic advance_state(input step_req_t r, output state_out_t o);
        longint lm [3];
        longint gy [3];
        longint h [3];
        longint qn [4];
        longint dt, t, nw, react, net, d, w, x, y, z;
        o.skipped = 0;
        if (r.load) begin
            foreach (qn[i]) qn[i] = r.lq[i];
            renormalize(qn);
            foreach (rate[i]) begin
                rate[i] = r.lr[i];
                wheel[i] = 0;
            end
        end
        else if (r.dt <= 0) o.skipped = 1;
        else begin
            dt = r.dt;
            foreach (lm[i]) lm[i] = sat32f((inert[i] * rate[i]) >>> 16);
            gy[0] = sat32f((rate[1] * lm[2] - rate[2] * lm[1]) >>> 16);
            gy[1] = sat32f((rate[2] * lm[0] - rate[0] * lm[2]) >>> 16);
            gy[2] = sat32f((rate[0] * lm[1] - rate[1] * lm[0]) >>> 16);
            for (int i = 0; i < 3; i++) begin
                t = clampm(r.tq[i], lim_torque);
                nw = clampm(wheel[i] + div_big(-t * dt, jw), lim_speed);
                react = sat32f(-div_big((nw - wheel[i]) * jw, dt));
                net = sat32f(react - gy[i]);
                d = sat32f(div_big(net * 65536, inert[i]));
                wheel[i] = nw;
                rate[i] = sat32f(rate[i] + ((d * dt) >>> 16));
            end
            foreach (h[i]) h[i] = sat32f((rate[i] * dt) >>> 17);
            w = att[0];
            x = att[1];
            y = att[2];
            z = att[3];
            qn[0] = w - ((x * h[0]) >>> 16) - ((y * h[1]) >>> 16) - ((z * h[2]) >>> 16);
            qn[1] = x + ((w * h[0]) >>> 16) + ((y * h[2]) >>> 16) - ((z * h[1]) >>> 16);
            qn[2] = y + ((w * h[1]) >>> 16) + ((z * h[0]) >>> 16) - ((x * h[2]) >>> 16);
            qn[3] = z + ((w * h[2]) >>> 16) + ((x * h[1]) >>> 16) - ((y * h[0]) >>> 16);
            renormalize(qn);
        end
        for (int i = 0; i < 4; i++) o.data[32*i +: 32] = att[i][31:0];
        for (int i = 0; i < 3; i++) begin
            o.data[128 + 32*i +: 32] = rate[i][31:0];
            o.data[224 + 32*i +: 32] = wheel[i][31:0];
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic int rand_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
        return $urandom_range(0, 4);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 0;
            3: return $urandom_range(0, 200000) - 100000;
            4: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_cfg();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 1;
            2: return 0;
            3: return $urandom_range(1, 1 << 20);
            default: return $urandom & 32'h7fff_ffff;
        endcase
    endfunction

    function automatic step_req_t rand_step();
        step_req_t r;
        r.load = ($urandom_range(0, 9) == 0);
        r.dt = ($urandom_range(0, 9) == 0) ? rand_word() :
               ($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1 << 14));
        foreach (r.tq[i]) r.tq[i] = rand_word();
        foreach (r.lq[i]) r.lq[i] = ($urandom_range(0, 1)) ? rand_word() :
                                    $urandom_range(0, 1 << 31) - (1 << 30);
        foreach (r.lr[i]) r.lr[i] = ($urandom_range(0, 2) == 0) ? rand_word() :
                                    $urandom_range(0, 1 << 18) - (1 << 17);
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_MAX_TORQUE:    lim_torque = val[30:0];
            CFG_WHEEL_INERTIA: jw = val[30:0];
            CFG_MAX_SPEED:     lim_speed = val[30:0];
            CFG_INERTIA_X:     inert[0] = val[30:0];
            CFG_INERTIA_Y:     inert[1] = val[30:0];
            CFG_INERTIA_Z:     inert[2] = val[30:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic drain_all();
        while (pending_steps.size() != 0 || expected_states.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 0;
            s_tdata <= 0;
            s_tuser <= 0;
            gap_left <= 0;
        end
        else if (!s_tvalid || s_tready_q) begin
            if (gap_left > 0 || pending_steps.size() == 0 || !feeding) begin
                s_tvalid <= 0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
            else begin
                s_tvalid <= 1;
                s_tuser <= pending_steps[0].load;
                for (int i = 0; i < 3; i++) s_tdata[32*i +: 32] <= pending_steps[0].tq[i];
                s_tdata[96 +: 32] <= pending_steps[0].dt;
                for (int i = 0; i < 4; i++)
                    s_tdata[128 + 32*i +: 32] <= pending_steps[0].lq[i];
                for (int i = 0; i < 3; i++)
                    s_tdata[256 + 32*i +: 32] <= pending_steps[0].lr[i];
                gap_left <= rand_gap();
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) s_tready_q <= 0;
        else begin
            s_tready_q <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                state_out_t o;
                advance_state(pending_steps.pop_front(), o);
                expected_states.push_back(o);
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_states.size() == 0) begin
                report_mismatch("unexpected item", m_tdata[31:0], 0);
            end
            else begin
                state_out_t e;
                e = expected_states.pop_front();
                for (int i = 0; i < 10; i++)
                    if (m_tdata[32*i +: 32] !== e.data[32*i +: 32])
                        report_mismatch($sformatf("field %0d", i), m_tdata[32*i +: 32],
                                        e.data[32*i +: 32]);
                if (m_tuser !== e.skipped) report_mismatch("step_skipped", m_tuser, e.skipped);
            end
        end
    end

    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 0;
            stall_left <= 0;
        end
        else if (stall_left > 0) begin
            m_tready <= 0;
            stall_left <= stall_left - 1;
        end
        else begin
            m_tready <= 1;
            if ($urandom_range(0, 3) == 0) stall_left <= rand_gap();
        end
    end

    initial begin
        step_req_t r;
        logic [31:0] cfg_vals [6];
        errors = 0;
        feeding = 0;
        lim_torque = 65536;
        jw = 65536;
        lim_speed = 65536;
        inert = '{65536, 65536, 65536};
        att = '{64'sd1073741824, 0, 0, 0};
        rate = '{0, 0, 0};
        wheel = '{0, 0, 0};
        cfg_valid = 0;
        cfg_index = CFG_MAX_TORQUE;
        cfg_data = 0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        #1 rst_n = 1;

        // directed: reset config, then extremes and special cases
        r = '{load: 0, tq: '{65536, -65536, 0}, dt: 0, lq: '{0, 0, 0, 0}, lr: '{0, 0, 0}};
        pending_steps.push_back(r);
        r.dt = 32'h8000_0000;
        pending_steps.push_back(r);
        r.dt = 32'h0000_1000;
        r.tq = '{32'h7fff_ffff, 32'h8000_0000, 32'h0001_8000};
        pending_steps.push_back(r);
        pending_steps.push_back(r);
        r.dt = 32'h7fff_ffff;
        pending_steps.push_back(r);
        r.load = 1;
        r.lq = '{0, 0, 0, 0};
        r.lr = '{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000};
        pending_steps.push_back(r);
        r.lq = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
        pending_steps.push_back(r);
        r.load = 0;
        r.dt = 1;
        pending_steps.push_back(r);
        r.load = 1;
        r.lq = '{1, 0, 0, 0};
        r.lr = '{32'h0000_8000, 32'hffff_0000, 32'h0002_0000};
        pending_steps.push_back(r);
        r.load = 0;
        r.dt = 32'h0000_4000;
        repeat (3) pending_steps.push_back(r);
        feeding = 1;
        drain_all();

        // lowered wheel speed limit with wheels already spinning, zero inertias, extremes
        feeding = 0;
        write_reg(CFG_MAX_SPEED, 32'd100);
        write_reg(CFG_INERTIA_X, 32'd0);
        write_reg(CFG_INERTIA_Y, 32'h7fff_ffff);
        write_reg(CFG_INERTIA_Z, 32'd1);
        write_reg(CFG_WHEEL_INERTIA, 32'd0);
        write_reg(CFG_MAX_TORQUE, 32'h7fff_ffff);
        r.tq = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0100};
        r.dt = 32'h0000_4000;
        pending_steps.push_back(r);
        r.load = 1;
        pending_steps.push_back(r);
        r.load = 0;
        pending_steps.push_back(r);
        feeding = 1;
        drain_all();

        for (int phase = 0; phase < 10; phase++) begin
            feeding = 0;
            if (phase == 9) cfg_vals = '{65536, 65536, 65536, 65536, 65536, 65536};
            else if (phase == 8)
                cfg_vals = '{32'h7fff_ffff, 1, 32'h7fff_ffff, 1, 1, 1};
            else if (phase == 7) cfg_vals = '{0, 32'h7fff_ffff, 0, 32'h7fff_ffff,
                                               32'h7fff_ffff, 32'h7fff_ffff};
            else foreach (cfg_vals[i]) cfg_vals[i] = rand_cfg();
            for (int i = 0; i < 6; i++) write_reg(3'(i), cfg_vals[i] | ($urandom & 32'h8000_0000));
            // out-of-range index must be ignored
            write_reg(3'd6 + 3'($urandom_range(0, 1)), $urandom);
            for (int k = 0; k < 100; k++) pending_steps.push_back(rand_step());
            feeding = 1;
            drain_all();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #100ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
